FILE: rtl/fwc_pkg.sv
// fwc_pkg: shared types and constants of the flash-ADC word compressor.
// No dependencies.
package fwc_pkg;

    localparam int StampW     = 20;
    localparam int CountW     = 8;
    localparam int DataW      = 12;
    localparam int SampleW    = 13;
    localparam int CodeW      = 28;
    localparam int LenW       = 5;
    localparam int NumSamples = 4;
    localparam int QueueDepth = 2;

    localparam logic [CountW-1:0] RunMax = 8'd255;

    localparam logic [LenW-1:0] LenRun   = 5'd28;
    localparam logic [LenW-1:0] LenShort = 5'd4;
    localparam logic [LenW-1:0] LenEsc   = 5'd17;

    localparam logic SecRun    = 1'b0;
    localparam logic SecSample = 1'b1;

    localparam logic [2:0] StepRec0    = 3'd0;
    localparam logic [2:0] StepRec1    = 3'd1;
    localparam logic [2:0] StepSmp0    = 3'd2;
    localparam logic [2:0] StepSmpLast = 3'd5;

    typedef struct packed {
        logic               esc;
        logic [SampleW-1:0] val;
    } t_smp;

    typedef struct packed {
        logic                       rec0_valid;
        logic [CodeW-1:0]           rec0;
        logic                       rec1_valid;
        logic [CodeW-1:0]           rec1;
        t_smp [NumSamples-1:0]      smp;
    } t_job;

endpackage

FILE: rtl/fwc_if.sv
// fwc_if: valid/ready channel interfaces for ADC words and result codes.
// Depends on nothing.
interface fwc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] time_stamp;
    logic [3:0]  overflow_flags;
    logic [11:0] adc_b0;
    logic [11:0] adc_a0;
    logic [11:0] adc_b1;
    logic [11:0] adc_a1;
    logic        final_word;

    modport source (output valid, time_stamp, overflow_flags, adc_b0, adc_a0, adc_b1,
                    adc_a1, final_word, input ready);
    modport sink (input valid, time_stamp, overflow_flags, adc_b0, adc_a0, adc_b1,
                  adc_a1, final_word, output ready);
endinterface

interface fwc_out_if;
    logic        valid;
    logic        ready;
    logic        section;
    logic [27:0] code_bits;
    logic [4:0]  code_length;
    logic        last_of_item;

    modport source (output valid, section, code_bits, code_length, last_of_item,
                    input ready);
    modport sink (input valid, section, code_bits, code_length, last_of_item,
                  output ready);
endinterface

FILE: rtl/fwc_front.sv
// fwc_front: accepts ADC words, tracks timestamp runs and sample deltas,
// and builds one job per word. Depends on fwc_pkg and fwc_if.
module fwc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fwc_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output fwc_pkg::t_job o_job
);
    import fwc_pkg::*;

    logic [StampW-1:0]  r_prev_stamp, n_prev_stamp;
    logic               r_run_open, n_run_open;
    logic [StampW-1:0]  r_run_start, n_run_start;
    logic [CountW-1:0]  r_run_count, n_run_count;
    logic [SampleW-1:0] r_prev_sample, n_prev_sample;

    logic                             goes_on;
    logic [StampW-1:0]                new_start;
    logic [CountW-1:0]                new_count;
    logic [NumSamples-1:0][SampleW-1:0] samples;
    logic [SampleW-1:0]               last_sample;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    assign samples[0] = {i_in.overflow_flags[0], i_in.adc_a1};
    assign samples[1] = {i_in.overflow_flags[1], i_in.adc_b1};
    assign samples[2] = {i_in.overflow_flags[2], i_in.adc_a0};
    assign samples[3] = {i_in.overflow_flags[3], i_in.adc_b0};

    assign goes_on = r_run_open && (r_prev_stamp != {StampW{1'b1}}) &&
                     (i_in.time_stamp == r_prev_stamp + StampW'(1)) &&
                     (r_run_count != RunMax);

    assign new_start = goes_on ? r_run_start : i_in.time_stamp;
    assign new_count = goes_on ? r_run_count + CountW'(1) : CountW'(1);

    always_comb begin
        logic [SampleW-1:0]   prev;
        logic signed [SampleW:0] diff;
        prev = r_prev_sample;
        o_job.rec0_valid = r_run_open && !goes_on;
        o_job.rec0       = {r_run_start, r_run_count};
        o_job.rec1_valid = i_in.final_word;
        o_job.rec1       = {new_start, new_count};
        for (int k = 0; k < NumSamples; k++) begin
            diff = $signed({1'b0, samples[k]}) - $signed({1'b0, prev});
            if (diff <= $signed(14'sd7) && diff >= $signed(-14'sd7)) begin
                o_job.smp[k].esc = 1'b0;
                o_job.smp[k].val = SampleW'(samples[k] - prev + SampleW'(8));
            end else begin
                o_job.smp[k].esc = 1'b1;
                o_job.smp[k].val = samples[k];
            end
            prev = samples[k];
        end
        last_sample = prev;
    end

    always_comb begin
        n_prev_stamp  = r_prev_stamp;
        n_run_open    = r_run_open;
        n_run_start   = r_run_start;
        n_run_count   = r_run_count;
        n_prev_sample = r_prev_sample;
        if (o_push) begin
            n_prev_stamp = i_in.time_stamp;
            if (i_in.final_word) begin
                n_run_open    = 1'b0;
                n_run_start   = '0;
                n_run_count   = '0;
                n_prev_sample = '0;
            end else begin
                n_run_open    = 1'b1;
                n_run_start   = new_start;
                n_run_count   = new_count;
                n_prev_sample = last_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_stamp  <= '0;
            r_run_open    <= 1'b0;
            r_run_start   <= '0;
            r_run_count   <= '0;
            r_prev_sample <= '0;
        end else begin
            r_prev_stamp  <= n_prev_stamp;
            r_run_open    <= n_run_open;
            r_run_start   <= n_run_start;
            r_run_count   <= n_run_count;
            r_prev_sample <= n_prev_sample;
        end
    end

endmodule

FILE: rtl/fwc_queue.sv
// fwc_queue: short job queue between the front and back parts.
// Depends on fwc_pkg.
module fwc_queue #(
    parameter int QUEUE_DEPTH = fwc_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fwc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_avail,
    output fwc_pkg::t_job o_job
);
    import fwc_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

    t_job            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    assign o_full  = (r_count == CntW'(QUEUE_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + PtrW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CntW'(1);
            2'b01:   n_count = r_count - CntW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: rtl/fwc_back.sv
// fwc_back: walks the head job and emits its codes, one per cycle while
// output is ready, via a registered output stage. Uses fwc_pkg, fwc_if.
module fwc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_avail,
    input  fwc_pkg::t_job i_job,
    output logic          o_pop,
    fwc_out_if.source     o_out
);
    import fwc_pkg::*;

    logic [2:0]       r_step, n_step;
    logic [2:0]       cur;
    logic [1:0]       smp_idx;
    t_smp             smp;
    logic             load;
    logic             r_valid;
    logic             r_section;
    logic [CodeW-1:0] r_bits;
    logic [LenW-1:0]  r_len;
    logic             r_last;

    assign load = i_avail && (!r_valid || o_out.ready);

    always_comb begin
        cur = r_step;
        if (r_step == StepRec0 && !i_job.rec0_valid) begin
            cur = i_job.rec1_valid ? StepRec1 : StepSmp0;
        end else if (r_step == StepRec1 && !i_job.rec1_valid) begin
            cur = StepSmp0;
        end
    end

    assign smp_idx = 2'(cur - StepSmp0);
    assign smp     = i_job.smp[smp_idx];
    assign o_pop   = load && (cur == StepSmpLast);
    assign n_step  = !load ? r_step : (o_pop ? StepRec0 : cur + 3'd1);

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_last <= (cur == StepSmpLast);
            case (cur)
                StepRec0: begin
                    r_section <= SecRun;
                    r_bits    <= i_job.rec0;
                    r_len     <= LenRun;
                end
                StepRec1: begin
                    r_section <= SecRun;
                    r_bits    <= i_job.rec1;
                    r_len     <= LenRun;
                end
                default: begin
                    r_section <= SecSample;
                    if (smp.esc) begin
                        r_bits <= CodeW'(smp.val);
                        r_len  <= LenEsc;
                    end else begin
                        r_bits <= CodeW'(smp.val[3:0]);
                        r_len  <= LenShort;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= StepRec0;
            r_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.section      = r_section;
    assign o_out.code_bits    = r_bits;
    assign o_out.code_length  = r_len;
    assign o_out.last_of_item = r_last;

endmodule

FILE: rtl/fadc_word_compressor.sv
// fadc_word_compressor: run-length timestamp and delta sample coder.
// A word's job is held in the queue; codes leave via a registered stage.
// Output: 4 to 6 codes per word, one code per cycle on the single
// result channel while it is ready; a closed run and a flush give 6 codes.
// A two-job queue lets the input take new words while codes drain.
// Reset (synchronous, active low) clears run state, queue and output valid.
module fadc_word_compressor #(
    parameter int QUEUE_DEPTH = fwc_pkg::QueueDepth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fwc_in_if.sink    i_in,
    fwc_out_if.source o_out
);
    import fwc_pkg::*;

    logic full;
    logic push;
    logic avail;
    logic pop;
    t_job push_job;
    t_job head_job;

    fwc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    fwc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_avail (avail),
        .o_job   (head_job)
    );

    fwc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
